>>> rtl/fmva_pkg.sv
// fmva_pkg: request/response payload types, opcodes, event kinds and the
// controller/datapath command and status structs of the FM voice allocator.
// No dependencies.
package fmva_pkg;

   localparam int NUM_CHANNELS = 16;

   // request operations
   localparam logic [2:0] OP_NOTE_OFF = 3'd0;
   localparam logic [2:0] OP_NOTE_ON  = 3'd1;
   localparam logic [2:0] OP_BEND     = 3'd2;
   localparam logic [2:0] OP_CONTROL  = 3'd3;
   localparam logic [2:0] OP_PROGRAM  = 3'd4;
   localparam logic [2:0] OP_RESET    = 3'd5;

   // response event kinds
   localparam logic [1:0] KIND_STOP   = 2'd0;
   localparam logic [1:0] KIND_START  = 2'd1;
   localparam logic [1:0] KIND_BEND   = 2'd2;
   localparam logic [1:0] KIND_VOLUME = 2'd3;

   // register indexes
   localparam logic [1:0] CSR_VOICE_COUNT = 2'd0;
   localparam logic [1:0] CSR_VOLUME_SCALE = 2'd1;
   localparam logic [1:0] CSR_TRANSPOSE   = 2'd2;

   localparam logic [3:0] DRUM_CHANNEL     = 4'd9;
   localparam logic [7:0] DRUM_PATCH_BASE  = 8'd93;
   localparam logic [7:0] TRANSPOSE_STEP   = 8'd12;
   localparam logic [6:0] MAIN_VOLUME_CTL  = 7'd7;
   localparam logic [7:0] NO_PATCH         = 8'd255;
   localparam logic [7:0] NO_KEY           = 8'd255;
   localparam logic [6:0] RESET_STOP_LEVEL = 7'd64;

   // floor(p / 100) == (p * 5243) >> 19 for every p below 16384
   localparam logic [12:0] PCT_RECIP = 13'd5243;
   localparam int          PCT_SHIFT = 19;

   localparam logic [4:0] COUNT_RESET  = 5'd16;
   localparam logic [6:0] SCALE_RESET  = 7'd100;

   typedef struct packed {
      logic [2:0] operation;
      logic [3:0] channel;
      logic [6:0] note;
      logic [6:0] velocity;
      logic [6:0] controller;
      logic [6:0] value;
      logic [6:0] program_req;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [3:0]  voice;
      logic [7:0]  patch;
      logic [7:0]  key;
      logic [6:0]  level;
      logic [13:0] bend_amount;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic load;   // capture request
      logic mul;    // value * scale
      logic div;    // percent divide, clear scan index
      logic step;   // act on current voice, advance index
      logic flush;  // send pending event as the last one
   } cmd_type;

   typedef struct packed {
      logic hit;        // current voice matches the operation
      logic single_op;  // operation stops at its first match
      logic idx_last;   // current voice is the last one in use
      logic n_zero;     // no voice in use
      logic pend_valid; // an event waits in the pending slot
      logic out_free;   // output register can load this cycle
   } status_type;

endpackage

>>> rtl/fmva_ctrl.sv
// fmva_ctrl: sequencing state machine of the voice allocator.
// Depends on fmva_pkg (cmd_type, status_type).
module fmva_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  fmva_pkg::status_type status,
   output fmva_pkg::cmd_type    cmd
);
   import fmva_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_MUL   = 5'b00010,
      ST_DIV   = 5'b00100,
      ST_SCAN  = 5'b01000,
      ST_FLUSH = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.div  = 1'b1;
            state_in = status.n_zero ? ST_FLUSH : ST_SCAN;
         end
         ST_SCAN: begin
            // a new match must first push the pending event out
            if (!(status.hit && status.pend_valid && !status.out_free)) begin
               cmd.step = 1'b1;
               if ((status.hit && status.single_op) || status.idx_last) begin
                  state_in = ST_FLUSH;
               end
            end
         end
         ST_FLUSH: begin
            if (!status.pend_valid) begin
               state_in = ST_IDLE;
            end else if (status.out_free) begin
               cmd.flush = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

>>> rtl/fmva_datapath.sv
// fmva_datapath: voice and patch tables, settings registers, volume scaler,
// scan index, pending event slot and output register.
// Depends on fmva_pkg.
module fmva_datapath #(
   parameter int NUM_VOICES = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  fmva_pkg::req_type    req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output fmva_pkg::rsp_type    rsp_data,
   input  logic                 csr_wr_en,
   input  logic [1:0]           csr_index,
   input  logic [6:0]           csr_data,
   input  fmva_pkg::cmd_type    cmd,
   output fmva_pkg::status_type status
);
   import fmva_pkg::*;

   localparam int IW    = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
   localparam int LIMIT = (NUM_VOICES < 16) ? NUM_VOICES : 16;

   // settings
   logic [4:0] count_ff;
   logic [6:0] scale_ff;
   logic       xpose_ff;

   // tables
   logic             busy_ff  [NUM_VOICES];
   logic [6:0]       key_ff   [NUM_VOICES];
   logic [3:0]       chan_ff  [NUM_VOICES];
   logic [7:0]       patch_ff [NUM_CHANNELS];

   req_type     req_ff;
   logic [13:0] prod_ff, prod_in;
   logic [6:0]  level_ff, level_in;
   logic [IW-1:0] idx_ff, idx_in;
   rsp_type     pend_ff;
   logic        pend_valid_ff, pend_valid_in;
   rsp_type     rsp_ff, rsp_in;
   logic        rsp_valid_ff, rsp_valid_in;

   logic [4:0]  n_lim;
   logic        cur_busy;
   logic [6:0]  cur_key;
   logic        chan_match;
   logic        is_drum;
   logic        hit, single_op, has_event, out_free, load_out;
   logic [26:0] quot;
   logic [7:0]  quot_hi;
   rsp_type     new_ev;

   always_comb begin
      n_lim = count_ff;
      if (n_lim > 5'(LIMIT)) begin
         n_lim = 5'(LIMIT);
      end
   end

   assign cur_busy   = busy_ff[idx_ff];
   assign cur_key    = key_ff[idx_ff];
   assign chan_match = (chan_ff[idx_ff] == req_ff.channel);
   assign is_drum    = (req_ff.channel == DRUM_CHANNEL);

   always_comb begin
      hit       = 1'b0;
      single_op = 1'b0;
      has_event = 1'b0;
      new_ev       = '0;
      new_ev.voice = 4'(idx_ff);
      unique case (req_ff.operation)
         OP_NOTE_OFF: begin
            hit          = cur_busy && (cur_key == req_ff.note) && chan_match;
            single_op    = 1'b1;
            has_event    = 1'b1;
            new_ev.kind  = KIND_STOP;
            new_ev.key   = {1'b0, req_ff.note};
            new_ev.level = req_ff.velocity;
         end
         OP_NOTE_ON: begin
            hit          = !cur_busy;
            single_op    = 1'b1;
            has_event    = 1'b1;
            new_ev.kind  = KIND_START;
            new_ev.level = req_ff.velocity;
            if (is_drum) begin
               new_ev.patch = {1'b0, req_ff.note} + DRUM_PATCH_BASE;
               new_ev.key   = {1'b0, req_ff.note};
            end else begin
               new_ev.patch = patch_ff[req_ff.channel];
               new_ev.key   = xpose_ff ? ({1'b0, req_ff.note} + TRANSPOSE_STEP)
                                       : {1'b0, req_ff.note};
            end
         end
         OP_BEND: begin
            hit                = cur_busy && chan_match;
            has_event          = 1'b1;
            new_ev.kind        = KIND_BEND;
            new_ev.bend_amount = {req_ff.value, 7'd0};
         end
         OP_CONTROL: begin
            hit          = cur_busy && chan_match && (req_ff.controller == MAIN_VOLUME_CTL);
            has_event    = 1'b1;
            new_ev.kind  = KIND_VOLUME;
            new_ev.level = level_ff;
         end
         OP_PROGRAM: begin
            hit       = !cur_busy || chan_match;
            single_op = 1'b1;
         end
         OP_RESET: begin
            hit          = 1'b1;
            has_event    = 1'b1;
            new_ev.kind  = KIND_STOP;
            new_ev.key   = cur_busy ? {1'b0, cur_key} : NO_KEY;
            new_ev.level = RESET_STOP_LEVEL;
         end
         default: begin
            hit = 1'b0;
         end
      endcase
   end

   // volume percent: one multiply per cycle, register between them
   assign prod_in = 14'(req_ff.value) * 14'(scale_ff);
   assign quot    = 27'(prod_ff) * 27'(PCT_RECIP);
   assign quot_hi = quot[PCT_SHIFT+7:PCT_SHIFT];
   assign level_in = (quot_hi > 8'd127) ? 7'd127 : quot_hi[6:0];

   always_comb begin
      idx_in = idx_ff;
      if (cmd.div) begin
         idx_in = '0;
      end else if (cmd.step) begin
         idx_in = idx_ff + IW'(1);
      end
   end

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign load_out = (cmd.step && hit && pend_valid_ff) || cmd.flush;

   always_comb begin
      rsp_in      = pend_ff;
      rsp_in.last = cmd.flush;
   end

   always_comb begin
      pend_valid_in = pend_valid_ff;
      if (cmd.step && hit && has_event) begin
         pend_valid_in = 1'b1;
      end else if (cmd.flush) begin
         pend_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= COUNT_RESET;
         scale_ff      <= SCALE_RESET;
         xpose_ff      <= 1'b1;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         for (int i = 0; i < NUM_VOICES; i++) begin
            busy_ff[i] <= 1'b0;
         end
         for (int c = 0; c < NUM_CHANNELS; c++) begin
            patch_ff[c] <= NO_PATCH;
         end
      end else begin
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_VOICE_COUNT:  count_ff <= csr_data[4:0];
               CSR_VOLUME_SCALE: scale_ff <= csr_data;
               CSR_TRANSPOSE:    xpose_ff <= csr_data[0];
               default: ;
            endcase
         end
         if (cmd.step && hit) begin
            unique case (req_ff.operation)
               OP_NOTE_OFF: busy_ff[idx_ff] <= 1'b0;
               OP_NOTE_ON:  busy_ff[idx_ff] <= 1'b1;
               OP_RESET:    busy_ff[idx_ff] <= 1'b0;
               OP_PROGRAM:  patch_ff[req_ff.channel] <= {1'b0, req_ff.program_req};
               default: ;
            endcase
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_data;
      end
      if (cmd.mul) begin
         prod_ff <= prod_in;
      end
      if (cmd.div) begin
         level_ff <= level_in;
      end
      idx_ff <= idx_in;
      if (cmd.step && hit && (req_ff.operation == OP_NOTE_ON)) begin
         key_ff[idx_ff]  <= req_ff.note;
         chan_ff[idx_ff] <= req_ff.channel;
      end
      if (cmd.step && hit && has_event) begin
         pend_ff <= new_ev;
      end
      if (load_out) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign status.hit        = hit;
   assign status.single_op  = single_op;
   assign status.idx_last   = ((6'(idx_ff) + 6'd1) == {1'b0, n_lim});
   assign status.n_zero     = (n_lim == 5'd0);
   assign status.pend_valid = pend_valid_ff;
   assign status.out_free   = out_free;

endmodule

>>> rtl/fm_voice_allocator.sv
// A note on or off event leaves the pending slot for the output register as the scan closes;
// a bend, volume or reset event leaves it at the next matching voice's step or at the close.
// Requests are taken only in idle, one at a time: volume scaling (ST_MUL, ST_DIV), a scan
// of the n voices in use (at most 16), one entry per cycle unless rsp_ready stalls, a close.
// Reset (synchronous, active high) frees every voice, sets all channel patches to
// none and restores the settings to 16 voices, 100 percent volume, transpose on.
module fm_voice_allocator #(
   parameter int NUM_VOICES = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  fmva_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output fmva_pkg::rsp_type rsp_data,
   input  logic              csr_wr_en,
   input  logic [1:0]        csr_index,
   input  logic [6:0]        csr_data
);
   import fmva_pkg::*;

   cmd_type    cmd;
   status_type status;

   fmva_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   fmva_datapath #(
      .NUM_VOICES (NUM_VOICES)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .status    (status)
   );

endmodule

>>> rtl/fmva_checker.sv
// fmva_checker: port-level assertions for fm_voice_allocator, bound to the top.
// Depends on fmva_pkg.
module fmva_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input fmva_pkg::rsp_type rsp_data
);
   import fmva_pkg::*;

   // a held response keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   // reset empties the output register
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // one request at a time: busy right after an accept
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while previous still in work");

   // note on yields at most one event, so a start event is marked last
   a_start_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.kind == KIND_START) |-> rsp_data.last)
      else $error("start event not marked last");

   // bend events carry only the bend amount
   a_bend_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.kind == KIND_BEND) |->
         (rsp_data.level == 7'd0) && (rsp_data.key == 8'd0) && (rsp_data.patch == 8'd0))
      else $error("bend event with stray fields");

endmodule

bind fm_voice_allocator fmva_checker u_fmva_checker (.*);
